// ----- sv/hduf_pkg.sv -----
// Shared types and constants for the half-duplex UART with ring buffers.
`default_nettype none

package hduf_pkg;

    localparam int unsigned RX_DEPTH_DEF = 32;
    localparam int unsigned TX_DEPTH_DEF = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PAYLOAD_BITS = 8;
    localparam int unsigned OUTQ_DEPTH   = 4;

    localparam logic [7:0] BIT_PERIOD_RST = 8'd104;
    localparam logic [9:0] SHIFT_IDLE     = 10'h3FF;
    localparam logic [9:0] SHIFT_LOAD     = 10'h200;  // stop bit set, start bit low

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    // line mode codes
    localparam logic [1:0] MODE_LISTEN = 2'd0;
    localparam logic [1:0] MODE_RECV   = 2'd1;
    localparam logic [1:0] MODE_TX     = 2'd2;

    // register index on the APB port
    localparam logic REG_BIT_PERIOD = 1'b0;

    typedef struct packed {
        logic tx_line;
        logic pop_hit;
        logic push_refused;
        logic rx_available;
        logic transmitting;
        logic receiving;
        logic rx_overflow;
    } hduf_res_t;

    typedef struct packed {
        hduf_res_t         res;
        logic [BYTE_W-1:0] rx_byte;
    } hduf_out_t;

endpackage

`default_nettype wire

// ----- sv/hduf_core.sv -----
// Line engine: ring memories, pointers, bit timer and shifter.
`default_nettype none

module hduf_core
    import hduf_pkg::*;
#(
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        bit_period,
    input  wire logic              item_valid,
    input  wire logic [1:0]        cmd,
    input  wire logic [BYTE_W-1:0] tx_byte,
    input  wire logic              rx_line,
    output logic                   res_valid,
    output hduf_res_t              res,
    output logic [BYTE_W-1:0]      rx_rdata
);

    localparam int unsigned RPW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned TPW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
    localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
    localparam logic [3:0] FRAME_BITS = 4'(PAYLOAD_BITS + 1);

    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];

    logic [TPW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next, tx_wp_inc, tx_rp_inc;
    logic [RPW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next, rx_wp_inc, rx_rp_inc;
    logic [1:0]     mode_reg, mode_next;
    logic [7:0]     tick_reg, tick_next;
    logic [3:0]     bit_reg, bit_next, bit_inc;
    logic [9:0]     shift_reg, shift_next, shift_eff;
    logic           ovf_reg, ovf_next;
    logic           last_line_reg, last_line_next;
    logic           load_pend_reg, load_pend_next;
    logic [BYTE_W-1:0] tx_rdata_reg, rx_rdata_reg;
    logic [BYTE_W-1:0] rx_wdata;
    logic           res_valid_reg;
    hduf_res_t      res_reg, res_next;
    logic           tx_we, tx_re, rx_we, rx_re;
    logic           refused, tx_empty, fell;
    logic [8:0]     tick_inc;

    // a frame load leaves the data bits open; the byte read from the ring is ORed in the cycle after
    assign shift_eff = load_pend_reg ? (shift_reg | {1'b0, tx_rdata_reg, 1'b0}) : shift_reg;

    // received byte as it stands after the sample of data bit seven
    assign rx_wdata  = {rx_line, shift_eff[7:1]};

    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;
    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_empty  = (tx_wp_reg == tx_rp_reg);
    assign tick_inc  = {1'b0, tick_reg} + 9'd1;
    assign bit_inc   = bit_reg + 4'd1;
    assign fell      = last_line_reg & ~rx_line;

    always_comb begin
        tx_wp_next     = tx_wp_reg;
        tx_rp_next     = tx_rp_reg;
        rx_wp_next     = rx_wp_reg;
        rx_rp_next     = rx_rp_reg;
        mode_next      = mode_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_eff;
        ovf_next       = ovf_reg;
        last_line_next = last_line_reg;
        load_pend_next = 1'b0;
        tx_we          = 1'b0;
        tx_re          = 1'b0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        refused        = 1'b0;
        if (item_valid) begin
            unique case (cmd)
                CMD_TICK: begin
                    last_line_next = rx_line;
                    if (mode_reg == MODE_LISTEN) begin
                        if (fell) begin
                            mode_next  = MODE_RECV;
                            tick_next  = {1'b0, bit_period[7:1]};
                            bit_next   = '0;
                            shift_next = SHIFT_IDLE;
                        end
                    end else if (tick_inc < {1'b0, bit_period}) begin
                        tick_next = tick_inc[7:0];
                    end else begin
                        tick_next = '0;
                        if (mode_reg == MODE_RECV) begin
                            shift_next = {2'b00, rx_line, shift_eff[7:1]};
                            bit_next   = bit_inc;
                            if (bit_inc >= FRAME_BITS) begin
                                if (rx_wp_inc == rx_rp_reg) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    rx_we      = 1'b1;
                                    rx_wp_next = rx_wp_inc;
                                end
                                mode_next  = tx_empty ? MODE_LISTEN : MODE_TX;
                                bit_next   = '0;
                                shift_next = SHIFT_IDLE;
                            end
                        end else if (bit_reg != '0) begin
                            shift_next = {1'b1, shift_eff[9:1]};
                            bit_next   = bit_reg - 4'd1;
                        end else if (!tx_empty) begin
                            tx_re          = 1'b1;
                            tx_rp_next     = tx_rp_inc;
                            shift_next     = SHIFT_LOAD;
                            load_pend_next = 1'b1;
                            bit_next       = FRAME_BITS;
                        end else begin
                            mode_next  = MODE_LISTEN;
                            shift_next = SHIFT_IDLE;
                        end
                    end
                end
                CMD_PUSH: begin
                    if (tx_wp_inc == tx_rp_reg) begin
                        refused = 1'b1;
                    end else begin
                        tx_we      = 1'b1;
                        tx_wp_next = tx_wp_inc;
                        if (mode_reg == MODE_LISTEN) begin
                            mode_next  = MODE_TX;
                            tick_next  = '0;
                            bit_next   = '0;
                            shift_next = SHIFT_IDLE;
                        end
                    end
                end
                CMD_POP: begin
                    if (rx_wp_reg != rx_rp_reg) begin
                        rx_re      = 1'b1;
                        rx_rp_next = rx_rp_inc;
                    end
                end
                CMD_FLUSH: begin
                    tx_wp_next = '0;
                    tx_rp_next = '0;
                    rx_wp_next = '0;
                    rx_rp_next = '0;
                end
                default: begin
                end
            endcase
        end

        res_next.tx_line      = (mode_next == MODE_TX) ? shift_next[0] : 1'b1;
        res_next.pop_hit      = rx_re;
        res_next.push_refused = refused;
        res_next.rx_available = (rx_wp_next != rx_rp_next);
        res_next.transmitting = (mode_next == MODE_TX);
        res_next.receiving    = (mode_next == MODE_RECV);
        res_next.rx_overflow  = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            mode_reg      <= MODE_LISTEN;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= SHIFT_IDLE;
            ovf_reg       <= 1'b0;
            last_line_reg <= 1'b1;
            load_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            tx_wp_reg     <= tx_wp_next;
            tx_rp_reg     <= tx_rp_next;
            rx_wp_reg     <= rx_wp_next;
            rx_rp_reg     <= rx_rp_next;
            mode_reg      <= mode_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            ovf_reg       <= ovf_next;
            last_line_reg <= last_line_next;
            load_pend_reg <= load_pend_next;
            res_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            res_reg <= res_next;
        end
    end

    // transmit ring
    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wp_reg] <= tx_byte;
        end
        if (tx_re) begin
            tx_rdata_reg <= tx_mem[tx_rp_reg];
        end
    end

    // receive ring
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wp_reg] <= rx_wdata;
        end
        if (rx_re) begin
            rx_rdata_reg <= rx_mem[rx_rp_reg];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rx_rdata  = rx_rdata_reg;

endmodule

`default_nettype wire

// ----- sv/hduf_outq.sv -----
// Result queue: resolves the popped byte and buffers beats for the master side.
`default_nettype none

module hduf_outq
    import hduf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire hduf_res_t         in_res,
    input  wire logic [BYTE_W-1:0] rx_rdata,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output hduf_out_t              out_beat,
    output logic                   room
);

    localparam int unsigned AW = $clog2(OUTQ_DEPTH);
    localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

    hduf_out_t      q_reg [OUTQ_DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW:0]    fill;
    logic           pop;
    hduf_out_t      entry;

    assign entry.res     = in_res;
    assign entry.rx_byte = in_res.pop_hit ? rx_rdata : '0;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign out_beat = q_reg[rp_reg];
    // count the beat still in flight from the core
    assign fill     = {1'b0, cnt_reg} + {{CW{1'b0}}, in_valid};
    assign room     = (fill < (CW+1)'(OUTQ_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (in_valid) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(in_valid) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            q_reg[wp_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// ----- sv/half_duplex_uart_with_fifos.sv -----
// Top level: half-duplex 8N1 UART with transmit and receive rings, APB setup port.
// A result beat is registered in the core, then queued in hduf_outq and offered on m_.
// Throughput: one item per cycle while s_tready is high; every item is one read-modify-write
// of the pointer and timer registers plus at most one access to each ring memory.
// Reset: aresetn low at a clock edge clears pointers, mode, timer, shifter and
// flags and sets bit_period to 104; ring contents stay as they were.
`default_nettype none

module half_duplex_uart_with_fifos
    import hduf_pkg::*;
#(
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] tx_byte, [8] rx_line, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] tx_line, [8:1] rx_byte, [9] pop_valid,
                                        // [10] push_refused, [11] rx_available,
                                        // [12] transmitting, [13] receiving,
                                        // [14] rx_overflow, [15] zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]        bit_period_reg;
    logic              cfg_wr;
    logic              accept;
    logic              res_valid;
    hduf_res_t         res;
    logic [BYTE_W-1:0] rx_rdata;
    hduf_out_t         out_beat;
    logic              room;

    // APB: single register, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_BIT_PERIOD);
    assign prdata = (paddr[2] == REG_BIT_PERIOD) ? {24'd0, bit_period_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RST;
        end else if (cfg_wr) begin
            bit_period_reg <= pwdata[7:0];
        end
    end

    // ready depends only on queue fill, so the slave side keeps moving while
    // finished beats wait on the master side, until the result queue is full
    assign s_tready = room;
    assign accept   = s_tvalid & s_tready;

    hduf_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bit_period (bit_period_reg),
        .item_valid (accept),
        .cmd        (s_tuser),
        .tx_byte    (s_tdata[7:0]),
        .rx_line    (s_tdata[8]),
        .res_valid  (res_valid),
        .res        (res),
        .rx_rdata   (rx_rdata)
    );

    hduf_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .rx_rdata (rx_rdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_beat (out_beat),
        .room     (room)
    );

    assign m_tdata = {1'b0,
                      out_beat.res.rx_overflow,
                      out_beat.res.receiving,
                      out_beat.res.transmitting,
                      out_beat.res.rx_available,
                      out_beat.res.push_refused,
                      out_beat.res.pop_hit,
                      out_beat.rx_byte,
                      out_beat.res.tx_line};

endmodule

`default_nettype wire

// ----- verif/hduf_checker.sv -----
// Checker for the half-duplex UART: predicts every result beat and compares it.
`timescale 1ns / 1ps

module hduf_checker
    import hduf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] tx_byte, [8] rx_line
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [0] tx_line, [8:1] rx_byte, [9] pop_valid, [10] refused,
                                    // [11] rx_available, [12] transmitting, [13] receiving,
                                    // [14] rx_overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          n_results,
    output int          n_pop_hits,
    output int          n_rx_frames,
    output int          n_tx_frames,
    output int          n_refused,
    output logic        overflow_seen
);

    localparam logic [2:0] BIT_PERIOD_ADDR = {REG_BIT_PERIOD, 2'b00};

    // model state; depth 32 so 5-bit pointers wrap on their own
    logic [7:0] tx_mem [TX_DEPTH_DEF];
    logic [7:0] rx_mem [RX_DEPTH_DEF];
    logic [4:0] tx_wp, tx_rp, rx_wp, rx_rp;
    logic [1:0] mode;
    logic [7:0] tcount;
    logic [3:0] bidx;
    logic [9:0] shreg;
    logic       ovf;
    logic       prev_line;
    logic [7:0] period;

    logic [15:0] status_q [$];
    int errs, results, pops, rx_done, tx_loaded, refusals;

    function automatic void start_tx_mode();
        mode   = MODE_TX;
        tcount = '0;
        bidx   = '0;
        shreg  = SHIFT_IDLE;
    endfunction

    function automatic logic [15:0] advance_uart(input logic [1:0] cmd, input logic [7:0] txb,
                                                 input logic line);
        logic [7:0] rxb;
        logic       hit, refused, fell, txl;
        logic [8:0] cnt;
        rxb     = '0;
        hit     = 1'b0;
        refused = 1'b0;
        case (cmd)
            CMD_TICK: begin
                fell      = prev_line && !line;
                prev_line = line;
                if (mode == MODE_LISTEN) begin
                    if (fell) begin
                        mode   = MODE_RECV;
                        tcount = period >> 1;
                        bidx   = '0;
                        shreg  = SHIFT_IDLE;
                    end
                end else begin
                    cnt = {1'b0, tcount} + 9'd1;
                    if (cnt < {1'b0, period}) begin
                        tcount = cnt[7:0];
                    end else begin
                        tcount = '0;
                        if (mode == MODE_RECV) begin
                            shreg = {2'b00, line, shreg[7:1]};
                            bidx  = bidx + 4'd1;
                            if (bidx >= 4'(PAYLOAD_BITS + 1)) begin
                                rx_done++;
                                if (rx_wp + 5'd1 == rx_rp) begin
                                    ovf = 1'b1;
                                end else begin
                                    rx_mem[rx_wp] = shreg[7:0];
                                    rx_wp         = rx_wp + 5'd1;
                                end
                                if (tx_wp != tx_rp) begin
                                    start_tx_mode();
                                end else begin
                                    mode   = MODE_LISTEN;
                                    tcount = '0;
                                    bidx   = '0;
                                    shreg  = SHIFT_IDLE;
                                end
                            end
                        end else if (bidx != 0) begin
                            shreg = {1'b1, shreg[9:1]};
                            bidx  = bidx - 4'd1;
                        end else if (tx_wp != tx_rp) begin
                            shreg = SHIFT_LOAD | {1'b0, tx_mem[tx_rp], 1'b0};
                            tx_rp = tx_rp + 5'd1;
                            bidx  = 4'(PAYLOAD_BITS + 1);
                            tx_loaded++;
                        end else begin
                            mode   = MODE_LISTEN;
                            tcount = '0;
                            shreg  = SHIFT_IDLE;
                        end
                    end
                end
            end
            CMD_PUSH: begin
                if (tx_wp + 5'd1 == tx_rp) begin
                    refused = 1'b1;
                    refusals++;
                end else begin
                    tx_mem[tx_wp] = txb;
                    tx_wp         = tx_wp + 5'd1;
                    if (mode == MODE_LISTEN) start_tx_mode();
                end
            end
            CMD_POP: begin
                if (rx_wp != rx_rp) begin
                    rxb   = rx_mem[rx_rp];
                    rx_rp = rx_rp + 5'd1;
                    hit   = 1'b1;
                    pops++;
                end
            end
            default: begin
                tx_wp = '0;
                tx_rp = '0;
                rx_wp = '0;
                rx_rp = '0;
            end
        endcase
        txl = (mode == MODE_TX) ? shreg[0] : 1'b1;
        return {1'b0, ovf, mode == MODE_RECV, mode == MODE_TX, rx_wp != rx_rp,
                refused, hit, rxb, txl};
    endfunction

    function automatic int unsigned pick_field(input logic [15:0] w, input int idx,
                                               output string name);
        case (idx)
            0: begin name = "tx_line";      return 32'(w[0]);    end
            1: begin name = "rx_byte";      return 32'(w[8:1]);  end
            2: begin name = "pop_valid";    return 32'(w[9]);    end
            3: begin name = "push_refused"; return 32'(w[10]);   end
            4: begin name = "rx_available"; return 32'(w[11]);   end
            5: begin name = "transmitting"; return 32'(w[12]);   end
            6: begin name = "receiving";    return 32'(w[13]);   end
            7: begin name = "rx_overflow";  return 32'(w[14]);   end
            default: begin name = "pad";    return 32'(w[15]);   end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        logic [15:0]  want;
        int unsigned  fw, fa;
        string        fname;
        if (!aresetn) begin
            tx_wp     = '0;
            tx_rp     = '0;
            rx_wp     = '0;
            rx_rp     = '0;
            mode      = MODE_LISTEN;
            tcount    = '0;
            bidx      = '0;
            shreg     = SHIFT_IDLE;
            ovf       = 1'b0;
            prev_line = 1'b1;
            period    = BIT_PERIOD_RST;
            status_q.delete();
            errs = 0; results = 0; pops = 0; rx_done = 0; tx_loaded = 0; refusals = 0;
        end else begin
            if (psel && penable && pready && paddr == BIT_PERIOD_ADDR) begin
                if (pwrite) begin
                    period = pwdata[7:0];
                end else if (prdata !== {24'h0, period}) begin
                    $display("%t prdata bit_period: expected %0h, got %0h",
                             $time, {24'h0, period}, prdata);
                    errs++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $display("%t result beat: expected none, got %0h", $time, m_tdata);
                    errs++;
                end else begin
                    want = status_q.pop_front();
                    results++;
                    for (int i = 0; i < 9; i++) begin
                        fw = pick_field(want, i, fname);
                        fa = pick_field(m_tdata, i, fname);
                        if (fw !== fa) begin
                            $display("%t m_tdata %s: expected %0h, got %0h",
                                     $time, fname, fw, fa);
                            errs++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                status_q.push_back(advance_uart(s_tuser, s_tdata[7:0], s_tdata[8]));
        end
        fail_count    <= errs;
        pending       <= status_q.size();
        n_results     <= results;
        n_pop_hits    <= pops;
        n_rx_frames   <= rx_done;
        n_tx_frames   <= tx_loaded;
        n_refused     <= refusals;
        overflow_seen <= ovf;
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the half-duplex UART: stimulus, phases and verdict.
`timescale 1ns / 1ps

module tb_top;
    import hduf_pkg::*;

    localparam logic [2:0] BIT_PERIOD_ADDR = {REG_BIT_PERIOD, 2'b00};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] tx_byte, [8] rx_line, rest zero
    logic [1:0]  s_tuser  = '0;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] tx_line, [8:1] rx_byte, [9] pop_valid, [10] refused,
                                    // [11] rx_available, [12] transmitting, [13] receiving,
                                    // [14] rx_overflow, [15] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count, pending, n_results, n_pop_hits, n_rx_frames, n_tx_frames, n_refused;
    logic overflow_seen;

    // per-phase knobs: percent of cycles the sender idles / the sink stalls
    int idle_pct  = 0;
    int stall_pct = 0;
    int cur_period = 104;

    // line levels still to be played onto rx_line, one per tick beat
    bit rx_pin_q [$];

    always #5 aclk = ~aclk;

    half_duplex_uart_with_fifos uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hduf_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_results     (n_results),
        .n_pop_hits    (n_pop_hits),
        .n_rx_frames   (n_rx_frames),
        .n_tx_frames   (n_tx_frames),
        .n_refused     (n_refused),
        .overflow_seen (overflow_seen)
    );

    // sink backpressure, redrawn every cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // one input beat; random idle cycles ahead of it, returns at the accepting edge
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] txb, input logic line);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, line, txb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // sender holds off until every result beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // APB write, then read back; only done with nothing in flight
    task automatic write_bit_period(input logic [7:0] value);
        drain_results();
        cur_period = int'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIT_PERIOD_ADDR;
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);            // register written here
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);            // checker samples prdata here
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // byte with the extremes weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // 8N1 frame at the current bit period: start, data LSB first, stop, idle tail
    task automatic queue_frame(input logic [7:0] b, input int idle_after);
        repeat (cur_period) rx_pin_q.push_back(1'b0);
        for (int i = 0; i < 8; i++)
            repeat (cur_period) rx_pin_q.push_back(b[i]);
        repeat (cur_period + idle_after) rx_pin_q.push_back(1'b1);
    endtask

    // next tick beat; refill the pin pattern with mostly clean frames, some junk
    task automatic tick_from_pin();
        int k;
        if (rx_pin_q.size() == 0) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                queue_frame(pick_byte(), $urandom_range(0, 2 * cur_period));
            end else if (k == 7) begin
                // short low pulse: start bit not held, reception runs anyway
                repeat ($urandom_range(1, cur_period)) rx_pin_q.push_back(1'b0);
                repeat (cur_period) rx_pin_q.push_back(1'b1);
            end else begin
                repeat ($urandom_range(1, 16)) rx_pin_q.push_back(1'($urandom_range(0, 1)));
            end
        end
        send_beat(CMD_TICK, 8'($urandom_range(0, 255)), rx_pin_q.pop_front());
    endtask

    // weights are per mille; bursts fill the tx ring to force refused pushes
    task automatic run_random(input int n_items, input int push_w, input int pop_w,
                              input int flush_w, input bit bursts);
        int left, r, blen;
        left = n_items;
        rx_pin_q.delete();
        while (left > 0) begin
            r = $urandom_range(0, 999);
            if (bursts && r < 5) begin
                blen = $urandom_range(28, 36);
                repeat (blen) send_beat(CMD_PUSH, pick_byte(), 1'($urandom_range(0, 1)));
                left -= blen;
                if ($urandom_range(0, 1)) begin
                    send_beat(CMD_FLUSH, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    left--;
                end
            end else begin
                if (r < 5 + push_w)
                    send_beat(CMD_PUSH, pick_byte(), 1'($urandom_range(0, 1)));
                else if (r < 5 + push_w + pop_w)
                    send_beat(CMD_POP, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else if (r < 5 + push_w + pop_w + flush_w)
                    send_beat(CMD_FLUSH, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    tick_from_pin();
                left--;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: slowest bit period so the reception stays open throughout
        write_bit_period(8'd255);
        send_beat(CMD_POP,   8'h00, 1'b0);     // pop from empty ring reads zero
        send_beat(CMD_FLUSH, 8'hFF, 1'b1);     // flush with nothing queued
        send_beat(CMD_TICK,  8'h00, 1'b1);
        send_beat(CMD_TICK,  8'hFF, 1'b0);     // falling edge opens a reception
        repeat (3) send_beat(CMD_TICK, 8'h5A, 1'b0);
        send_beat(CMD_PUSH,  8'h00, 1'b1);     // pushes while receiving only queue
        send_beat(CMD_PUSH,  8'hFF, 1'b0);
        send_beat(CMD_POP,   8'h00, 1'b1);
        send_beat(CMD_FLUSH, 8'h00, 1'b0);     // pointers cleared, reception goes on
        send_beat(CMD_PUSH,  8'hA5, 1'b1);     // goes out once the reception ends
        send_beat(CMD_TICK,  8'h00, 1'b1);
        send_beat(CMD_TICK,  8'h00, 1'b0);
        send_beat(CMD_POP,   8'hFF, 1'b1);

        // shortest period while the timer sits far above it
        write_bit_period(8'd4);
        run_random(80, 12, 70, 3, 1'b1);

        // sender mostly idle; pause in the middle until all results are back
        write_bit_period(8'd6);
        idle_pct = 85;
        run_random(40, 10, 80, 3, 1'b1);
        drain_results();
        run_random(40, 10, 80, 3, 1'b1);
        idle_pct = 0;

        // sink mostly stalled; back-to-back frames without pops overrun the rx ring
        write_bit_period(8'd4);
        stall_pct = 85;
        rx_pin_q.delete();
        send_beat(CMD_FLUSH, 8'h00, 1'b1);
        repeat (60) send_beat(CMD_TICK, 8'h00, 1'b1);   // let a frame on the wire finish
        repeat (32) queue_frame(pick_byte(), 0);        // one more than the ring holds
        while (rx_pin_q.size() != 0)
            send_beat(CMD_TICK, 8'($urandom_range(0, 255)), rx_pin_q.pop_front());
        repeat (40) send_beat(CMD_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run_random(30, 10, 60, 3, 1'b0);

        // both sides idle at the longest bit period
        write_bit_period(8'd255);
        idle_pct  = 36;
        stall_pct = 36;
        run_random(50, 4, 40, 5, 1'b0);

        write_bit_period(8'd5);
        run_random(50, 12, 60, 3, 1'b1);

        // no idling, a mid-range period
        idle_pct  = 0;
        stall_pct = 0;
        write_bit_period(8'($urandom_range(7, 12)));
        run_random(40, 10, 60, 3, 1'b1);

        drain_results();
        repeat (8) @(posedge aclk);

        $display("checked %0d result beats over bit periods 4..255 with idle and stall phases",
                 n_results);
        $display("%0d bytes popped, %0d frames received, %0d sent, %0d pushes refused, overflow %0d",
                 n_pop_hits, n_rx_frames, n_tx_frames, n_refused, overflow_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("half_duplex_uart_with_fifos regression: pass");
        end else begin
            $display("half_duplex_uart_with_fifos regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("half_duplex_uart_with_fifos regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hduf_pkg.sv
sv/hduf_core.sv
sv/hduf_outq.sv
sv/half_duplex_uart_with_fifos.sv
verif/hduf_checker.sv
verif/tb_top.sv
